@@ src/utg_pkg.sv @@
package utg_pkg;

  typedef enum logic [1:0] {
    OP_CODE  = 2'd0,
    OP_GLYPH = 2'd1,
    OP_TEXT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_FALLBACK = 2'd1,
    ST_BAD      = 2'd2,
    ST_NOGLYPH  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_ROWREQ,
    S_ROWOUT,
    S_SINGLE
  } state_t;

  localparam logic [1:0] REG_FWE  = 2'd0;
  localparam logic [1:0] REG_EIU  = 2'd1;
  localparam logic [1:0] REG_FALL = 2'd2;

  localparam logic [15:0] FALLBACK_RESET = 16'd9633;

  function automatic logic [7:0] kana_lookup(input logic [5:0] i);
    logic [7:0] r;
    unique case (i)
      6'd0: r = 8'h02; 6'd1: r = 8'h0c; 6'd2: r = 8'h0d; 6'd3: r = 8'h01;
      6'd4: r = 8'hfb; 6'd5: r = 8'hf2; 6'd6: r = 8'ha1; 6'd7: r = 8'ha3;
      6'd8: r = 8'ha5; 6'd9: r = 8'ha7; 6'd10: r = 8'ha9; 6'd11: r = 8'he3;
      6'd12: r = 8'he5; 6'd13: r = 8'he7; 6'd14: r = 8'hc3; 6'd15: r = 8'hfc;
      6'd16: r = 8'ha2; 6'd17: r = 8'ha4; 6'd18: r = 8'ha6; 6'd19: r = 8'ha8;
      6'd20: r = 8'haa; 6'd21: r = 8'hab; 6'd22: r = 8'had; 6'd23: r = 8'haf;
      6'd24: r = 8'hb1; 6'd25: r = 8'hb3; 6'd26: r = 8'hb5; 6'd27: r = 8'hb7;
      6'd28: r = 8'hb9; 6'd29: r = 8'hbb; 6'd30: r = 8'hbd; 6'd31: r = 8'hbf;
      6'd32: r = 8'hc1; 6'd33: r = 8'hc4; 6'd34: r = 8'hc6; 6'd35: r = 8'hc8;
      6'd36: r = 8'hca; 6'd37: r = 8'hcb; 6'd38: r = 8'hcc; 6'd39: r = 8'hcd;
      6'd40: r = 8'hce; 6'd41: r = 8'hcf; 6'd42: r = 8'hd2; 6'd43: r = 8'hd5;
      6'd44: r = 8'hd8; 6'd45: r = 8'hdb; 6'd46: r = 8'hde; 6'd47: r = 8'hdf;
      6'd48: r = 8'he0; 6'd49: r = 8'he1; 6'd50: r = 8'he2; 6'd51: r = 8'he4;
      6'd52: r = 8'he6; 6'd53: r = 8'he8; 6'd54: r = 8'he9; 6'd55: r = 8'hea;
      6'd56: r = 8'heb; 6'd57: r = 8'hec; 6'd58: r = 8'hed; 6'd59: r = 8'hef;
      6'd60: r = 8'hf3; 6'd61: r = 8'h9b; 6'd62: r = 8'h9c;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] to_full_width(input logic [15:0] c);
    logic [15:0] r;
    logic [15:0] k;
    k = c - 16'hFF61;
    r = c;
    if (c == 16'h0020) r = 16'h3000;
    else if (c >= 16'h0021 && c <= 16'h007E) r = c - 16'h0020 + 16'hFF00;
    else if (c == 16'h00A2) r = 16'hFFE0;
    else if (c == 16'h00A3) r = 16'hFFE1;
    else if (c == 16'h00A5) r = 16'hFFE5;
    else if (c == 16'h00A6) r = 16'hFFE4;
    else if (c == 16'h00AC) r = 16'hFFE2;
    else if (c == 16'h00AF) r = 16'hFFE3;
    else if (c >= 16'hFF61 && c <= 16'hFF9F) r = {8'h30, kana_lookup(k[5:0])};
    return r;
  endfunction

endpackage

@@ src/utg_in_if.sv @@
interface utg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [10:0] entry_index;
  logic [2:0]  row_index;
  logic [15:0] code_value;
  logic [7:0]  glyph_byte;
  logic [7:0]  text_byte;
  modport source (output valid, op, entry_index, row_index, code_value, glyph_byte,
                  text_byte, input ready);
  modport sink (input valid, op, entry_index, row_index, code_value, glyph_byte,
                text_byte, output ready);
endinterface

@@ src/utg_out_if.sv @@
interface utg_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  row_data;
  logic [2:0]  row_number;
  logic        last;
  logic [1:0]  status;
  logic [15:0] code_point;
  modport source (output valid, row_data, row_number, last, status, code_point,
                  input ready);
  modport sink (input valid, row_data, row_number, last, status, code_point,
                output ready);
endinterface

@@ src/utf8_text_glyph_fetch.sv @@
// channel  dir  transfer
// in       in   load item or one UTF-8 text byte
// out      out  glyph row (GLYPH_ROWS+1 per char) or one status result
// apb      in   register write / read
// Load items and bytes that complete no character leave the block idle; a bad byte yields one status result.
// A character: accept, then per probe an address step (S_PROBE) and a compare step (S_CMP), up to
// 12 probes at depth 2048, plus one more S_PROBE step on a miss before the fallback search repeats
// the probes; then per row a request step (S_ROWREQ) and an output step (S_ROWOUT), for the eight
// rows; no glyph ends in a single status result (S_SINGLE). Output steps hold while out.ready is low.
// Reset clears decoder state and registers; memories are not cleared.
// Input is stalled while a character is searched or its rows or status result are delivered.
module utf8_text_glyph_fetch
  import utg_pkg::*;
#(
  parameter int TABLE_DEPTH = 2048,
  parameter int GLYPH_ROWS  = 7
) (
  input  logic        clk,
  input  logic        rst,
  utg_in_if.sink      in_ch,
  utg_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int GW = $clog2(TABLE_DEPTH * GLYPH_ROWS);
  localparam int RW = $clog2(GLYPH_ROWS + 1);
  localparam int NW = AW + 1;

  logic [15:0] code_table [TABLE_DEPTH];
  logic [7:0]  glyph_store [TABLE_DEPTH * GLYPH_ROWS];

  logic        fwe;
  logic [11:0] eiu;
  logic [15:0] fallback;

  state_t state, state_next;
  logic [15:0] partial;
  logic [1:0]  pending;
  logic [15:0] code;
  logic [15:0] key;
  logic        use_fb;
  logic [NW:0] low, high;
  logic [NW:0] mid;
  logic [AW-1:0] t_addr;
  logic [15:0] t_q;
  logic [GW-1:0] g_addr, g_base;
  logic [7:0]  g_q;
  logic [RW-1:0] row;
  status_t     st;

  logic        cfg_wr;
  logic        in_fire, out_fire;
  logic        text_char;
  logic [15:0] text_code;
  logic        text_bad;
  logic [NW-1:0] n_used;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwe      <= 1'b0;
      eiu      <= '0;
      fallback <= FALLBACK_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_FWE:  fwe <= pwdata[0];
        REG_EIU:  eiu <= pwdata[11:0];
        REG_FALL: fallback <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FWE:  prdata = {31'd0, fwe};
      REG_EIU:  prdata = {20'd0, eiu};
      REG_FALL: prdata = {16'd0, fallback};
      default:  prdata = '0;
    endcase
  end

  assign n_used = ({20'd0, eiu} > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(eiu);

  assign in_ch.ready = (state == S_IDLE);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  always_comb begin
    text_char = 1'b0;
    text_bad  = 1'b0;
    text_code = {8'd0, in_ch.text_byte};
    if (pending != 2'd0) begin
      if (in_ch.text_byte[7:6] != 2'b10) text_bad = 1'b1;
      else if (pending == 2'd1) begin
        text_char = 1'b1;
        text_code = {partial[9:0], in_ch.text_byte[5:0]};
      end
    end else if (in_ch.text_byte == 8'd0) begin
    end else if (!in_ch.text_byte[7]) text_char = 1'b1;
    else if (in_ch.text_byte[7:5] == 3'b110 || in_ch.text_byte[7:4] == 4'b1110) begin
    end else text_bad = 1'b1;
  end

  assign mid = low + ((high - low) >> 1);
  assign t_addr = mid[AW-1:0];

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.op == OP_CODE && {21'd0, in_ch.entry_index} < TABLE_DEPTH)
      code_table[in_ch.entry_index[AW-1:0]] <= in_ch.code_value;
    t_q <= code_table[t_addr];
  end

  assign g_addr = g_base + GW'(row);
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.op == OP_GLYPH && {21'd0, in_ch.entry_index} < TABLE_DEPTH
        && {29'd0, in_ch.row_index} < GLYPH_ROWS)
      glyph_store[GW'(in_ch.entry_index) * GW'(GLYPH_ROWS) + GW'(in_ch.row_index)]
        <= in_ch.glyph_byte;
    g_q <= glyph_store[g_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:
        if (in_fire && in_ch.op == OP_TEXT) begin
          if (text_bad) state_next = S_SINGLE;
          else if (text_char) state_next = S_PROBE;
        end
      S_PROBE: begin
        if ($signed(low) > $signed(high)) begin
          if (use_fb) state_next = S_SINGLE;
        end else state_next = S_CMP;
      end
      S_CMP:
        if (t_q == key) state_next = S_ROWREQ;
        else state_next = S_PROBE;
      S_ROWREQ: state_next = S_ROWOUT;
      S_ROWOUT:
        if (out_fire) begin
          if (row == RW'(GLYPH_ROWS)) state_next = S_IDLE;
          else state_next = S_ROWREQ;
        end
      S_SINGLE: if (out_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      partial <= '0;
      pending <= '0;
      use_fb  <= 1'b0;
      row     <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE:
          if (in_fire && in_ch.op == OP_TEXT) begin
            use_fb <= 1'b0;
            row    <= '0;
            low    <= '0;
            high   <= (NW+1)'(n_used) - 1'b1;
            if (pending != 2'd0) begin
              if (text_bad) begin
                pending <= '0;
                partial <= '0;
              end else begin
                pending <= pending - 1'b1;
                partial <= text_char ? 16'd0 : {partial[9:0], in_ch.text_byte[5:0]};
              end
            end else if (in_ch.text_byte[7:5] == 3'b110) begin
              partial <= {11'd0, in_ch.text_byte[4:0]};
              pending <= 2'd1;
            end else if (in_ch.text_byte[7:4] == 4'b1110) begin
              partial <= {12'd0, in_ch.text_byte[3:0]};
              pending <= 2'd2;
            end
            if (text_bad) begin
              st   <= ST_BAD;
              code <= '0;
            end else begin
              code <= fwe ? to_full_width(text_code) : text_code;
              key  <= fwe ? to_full_width(text_code) : text_code;
              st   <= ST_FOUND;
            end
          end
        S_PROBE:
          if ($signed(low) > $signed(high)) begin
            if (use_fb) st <= ST_NOGLYPH;
            else begin
              use_fb <= 1'b1;
              st     <= ST_FALLBACK;
              key    <= fallback;
              low    <= '0;
              high   <= (NW+1)'(n_used) - 1'b1;
            end
          end
        S_CMP:
          if (t_q == key) g_base <= GW'(t_addr) * GW'(GLYPH_ROWS);
          else if (t_q < key) low <= mid + 1'b1;
          else high <= mid - 1'b1;
        S_ROWOUT: if (out_fire) row <= row + 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_ch.valid      = (state == S_ROWOUT) || (state == S_SINGLE);
    out_ch.status     = st;
    out_ch.code_point = code;
    if (state == S_SINGLE) begin
      out_ch.row_data   = '0;
      out_ch.row_number = '0;
      out_ch.last       = 1'b1;
    end else begin
      out_ch.row_data   = (row == RW'(GLYPH_ROWS)) ? 8'd0 : g_q;
      out_ch.row_number = 3'(row);
      out_ch.last       = (row == RW'(GLYPH_ROWS));
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("input taken during output");
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_SINGLE) |-> (st == ST_BAD || st == ST_NOGLYPH))
    else $error("single result with row status");
  a_row_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> $stable(row)) else $error("row moved on stall");

endmodule

@@ tb/sv/utg_glyph_checker.sv @@
`timescale 1ns / 100ps
module utg_glyph_checker
  import utg_pkg::*;
#(
  parameter int TABLE_DEPTH = 2048,
  parameter int GLYPH_ROWS  = 7
) (
  input  logic        clk,
  input  logic        rst,
  utg_in_if           in_ch,
  utg_out_if          out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          rows_pending,
  output int          chars_seen
);

  typedef struct packed {
    logic [7:0]  row_data;
    logic [2:0]  row_number;
    logic        last;
    logic [1:0]  status;
    logic [15:0] code_point;
  } glyph_row_t;

  logic [15:0] code_mem [TABLE_DEPTH];
  logic [7:0]  pixel_mem [TABLE_DEPTH*GLYPH_ROWS];
  logic [15:0] acc_code;
  logic [1:0]  cont_left;
  logic        fw_en;
  logic [11:0] n_entries;
  logic [15:0] fb_code;
  glyph_row_t  row_queue [$];

  function automatic int find_code(input logic [15:0] key);
    int n, lo, hi, mid;
    n = (n_entries > TABLE_DEPTH) ? TABLE_DEPTH : int'(n_entries);
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (code_mem[mid] == key) return mid;
      if (code_mem[mid] < key) lo = mid + 1;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  function automatic logic [15:0] widen(input logic [15:0] c);
    logic [7:0] kana [63];
    kana = '{8'h02, 8'h0c, 8'h0d, 8'h01, 8'hfb, 8'hf2, 8'ha1, 8'ha3,
             8'ha5, 8'ha7, 8'ha9, 8'he3, 8'he5, 8'he7, 8'hc3, 8'hfc,
             8'ha2, 8'ha4, 8'ha6, 8'ha8, 8'haa, 8'hab, 8'had, 8'haf,
             8'hb1, 8'hb3, 8'hb5, 8'hb7, 8'hb9, 8'hbb, 8'hbd, 8'hbf,
             8'hc1, 8'hc4, 8'hc6, 8'hc8, 8'hca, 8'hcb, 8'hcc, 8'hcd,
             8'hce, 8'hcf, 8'hd2, 8'hd5, 8'hd8, 8'hdb, 8'hde, 8'hdf,
             8'he0, 8'he1, 8'he2, 8'he4, 8'he6, 8'he8, 8'he9, 8'hea,
             8'heb, 8'hec, 8'hed, 8'hef, 8'hf3, 8'h9b, 8'h9c};
    if (c == 16'h0020) return 16'h3000;
    if (c >= 16'h0021 && c <= 16'h007E) return c + 16'hFEE0;
    case (c)
      16'h00A2: return 16'hFFE0;
      16'h00A3: return 16'hFFE1;
      16'h00A5: return 16'hFFE5;
      16'h00A6: return 16'hFFE4;
      16'h00AC: return 16'hFFE2;
      16'h00AF: return 16'hFFE3;
      default: ;
    endcase
    if (c >= 16'hFF61 && c <= 16'hFF9F) return {8'h30, kana[c - 16'hFF61]};
    return c;
  endfunction

  task automatic push_status(input status_t st, input logic [15:0] cp);
    row_queue.push_back('{8'd0, 3'd0, 1'b1, st, cp});
  endtask

  task automatic predict_char(input logic [15:0] raw);
    logic [15:0] cp;
    int idx;
    status_t st;
    cp = fw_en ? widen(raw) : raw;
    st = ST_FOUND;
    idx = find_code(cp);
    chars_seen++;
    if (idx < 0) begin
      st = ST_FALLBACK;
      idx = find_code(fb_code);
    end
    if (idx < 0) begin
      push_status(ST_NOGLYPH, cp);
      return;
    end
    for (int r = 0; r <= GLYPH_ROWS; r++)
      row_queue.push_back('{(r < GLYPH_ROWS) ? pixel_mem[idx*GLYPH_ROWS + r] : 8'd0,
                            3'(r), r == GLYPH_ROWS, st, cp});
  endtask

  task automatic predict_byte(input logic [7:0] b);
    if (cont_left != 2'd0) begin
      if (b[7:6] != 2'b10) begin
        cont_left = 2'd0;
        acc_code = '0;
        push_status(ST_BAD, 16'd0);
        return;
      end
      acc_code = {acc_code[9:0], b[5:0]};
      cont_left--;
      if (cont_left == 2'd0) begin
        predict_char(acc_code);
        acc_code = '0;
      end
      return;
    end
    if (b == 8'd0) return;
    if (b < 8'h80) predict_char({8'd0, b});
    else if (b[7:5] == 3'b110) begin
      acc_code = {11'd0, b[4:0]};
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      acc_code = {12'd0, b[3:0]};
      cont_left = 2'd2;
    end else push_status(ST_BAD, 16'd0);
  endtask

  assign rows_pending = row_queue.size();

  always @(posedge clk) begin
    glyph_row_t got, want;
    if (rst) begin
      acc_code = '0;
      cont_left = 2'd0;
      fw_en <= 0;
      n_entries <= 0;
      fb_code <= FALLBACK_RESET;
      fail_count <= 0;
      chars_seen = 0;
      row_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_FWE:  fw_en <= pwdata[0];
          REG_EIU:  n_entries <= pwdata[11:0];
          REG_FALL: fb_code <= pwdata[15:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.row_data, out_ch.row_number, out_ch.last, out_ch.status,
                out_ch.code_point};
        if (row_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected row %h", got);
        end else begin
          want = row_queue.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp data %h row %0d last %b st %0d cp %h / got %h %0d %b %0d %h",
                       want.row_data, want.row_number, want.last, want.status,
                       want.code_point, got.row_data, got.row_number, got.last,
                       got.status, got.code_point);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        case (op_t'(in_ch.op))
          OP_CODE:  code_mem[in_ch.entry_index] = in_ch.code_value;
          OP_GLYPH: if (in_ch.row_index < GLYPH_ROWS)
                      pixel_mem[in_ch.entry_index*GLYPH_ROWS + in_ch.row_index] =
                        in_ch.glyph_byte;
          OP_TEXT:  predict_byte(in_ch.text_byte);
          default: ;
        endcase
      end
    end
  end

endmodule

@@ tb/sv/utf8_text_glyph_fetch_tb.sv @@
`timescale 1ns / 100ps
module utf8_text_glyph_fetch_tb;
  import utg_pkg::*;

  localparam int N_GLYPHS = 16;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  int fail_count, rows_pending, chars_seen;
  logic [15:0] font_codes [N_GLYPHS];

  utg_in_if in_ch();
  utg_out_if out_ch();

  utf8_text_glyph_fetch uut (.clk, .rst, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready);

  utg_glyph_checker chk (.clk, .rst, .in_ch, .out_ch, .psel, .penable, .pwrite,
    .paddr, .pwdata, .pready, .fail_count, .rows_pending, .chars_seen);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  initial begin
    out_ch.ready = 0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) < 60) || (gap_len() == 0);
    end
  end

  task automatic send(input op_t op, input logic [10:0] ei, input logic [2:0] ri,
                      input logic [15:0] cv, input logic [7:0] gb, input logic [7:0] tb);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.op <= op;
    in_ch.entry_index <= ei;
    in_ch.row_index <= ri;
    in_ch.code_value <= cv;
    in_ch.glyph_byte <= gb;
    in_ch.text_byte <= tb;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic txt(input logic [7:0] b);
    send(OP_TEXT, 11'($urandom), 3'($urandom), 16'($urandom), 8'($urandom), b);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic put_utf8(input logic [15:0] c);
    if (c < 16'h80) txt(c[7:0]);
    else if (c < 16'h800) begin
      txt({3'b110, c[10:6]});
      txt({2'b10, c[5:0]});
    end else begin
      txt({4'b1110, c[15:12]});
      txt({2'b10, c[11:6]});
      txt({2'b10, c[5:0]});
    end
  endtask

  function automatic logic [15:0] pick_char();
    int p;
    p = $urandom_range(99);
    if (p < 45) return font_codes[$urandom_range(N_GLYPHS - 1)];
    if (p < 60) return 16'($urandom_range(16'h7F, 16'h20));
    if (p < 70) return 16'hFF61 + 16'($urandom_range(62));
    if (p < 78) return 16'($urandom_range(16'hFF, 16'hA0));
    return 16'($urandom_range(16'hFFFF, 16'h1));
  endfunction

  initial begin
    int items, sorted_hi;
    logic [15:0] c;
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_ch.valid = 0; in_ch.op = OP_NONE; in_ch.entry_index = 0; in_ch.row_index = 0;
    in_ch.code_value = 0; in_ch.glyph_byte = 0; in_ch.text_byte = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // font: sorted codes spanning ascii, full-width, the U+3000 block, latin, and the extremes
    font_codes[0] = 16'h0000;
    font_codes[N_GLYPHS - 1] = 16'hFFFF;
    for (int i = 1; i < N_GLYPHS - 1; i++) begin
      case (i % 6)
        0: c = 16'h0020 + 16'(i);
        1: c = 16'hFF00 + 16'(i);
        2: c = 16'h3000 + 16'(4 * i);
        3: c = 16'h00A0 + 16'(i % 16);
        4: c = 16'h25A1;
        default: c = 16'($urandom);
      endcase
      font_codes[i] = c;
    end
    font_codes.sort();
    for (int i = 0; i < N_GLYPHS; i++) begin
      send(OP_CODE, 11'(i), 3'd0, font_codes[i], 8'd0, 8'd0);
      for (int r = 0; r < 7; r++)
        send(OP_GLYPH, 11'(i), 3'(r), 16'd0, (i == 1 && r == 0) ? 8'hFF : 8'($urandom),
             8'd0);
    end
    send(OP_CODE, 11'd2047, 3'd7, 16'hFFFF, 8'hFF, 8'd0);
    send(OP_GLYPH, 11'd2047, 3'd7, 16'hFFFF, 8'hFF, 8'd0);
    send(OP_NONE, 11'h7FF, 3'd7, 16'hFFFF, 8'hFF, 8'hFF);
    sorted_hi = N_GLYPHS;

    // empty table: every char has no glyph
    txt(8'h41);
    txt(8'h00);
    drain();
    write_reg(REG_EIU, 32'(sorted_hi));
    txt(8'h20); txt(8'h7E); txt(8'hC2); txt(8'hA2);
    txt(8'hEF); txt(8'hBD); txt(8'hA1);
    txt(8'h80); txt(8'hF0); txt(8'hFF);
    txt(8'hE3); txt(8'h41);
    txt(8'hC3); txt(8'h00);
    txt(8'hE0); txt(8'h80); txt(8'hC0);
    txt(8'hC0); txt(8'h80);
    txt(8'hEF); txt(8'hBF); txt(8'hBF);
    drain();
    write_reg(REG_FWE, 32'd1);
    write_reg(REG_FALL, 32'hFFFF);
    txt(8'h20); txt(8'h21); txt(8'hC2); txt(8'hAF); txt(8'hEF); txt(8'hBE); txt(8'h9F);
    drain();
    write_reg(REG_FALL, 32'h0012);
    txt(8'h7E);
    drain();

    items = 0;
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      write_reg(REG_FWE, 32'(phase & 1));
      write_reg(REG_EIU, (phase == 3) ? 32'd1 : 32'($urandom_range(sorted_hi, sorted_hi / 2)));
      write_reg(REG_FALL, (phase == 2) ? 32'h1234 : 32'(font_codes[$urandom_range(N_GLYPHS - 1)]));
      for (int k = 0; k < 20; k++) begin
        if ($urandom_range(99) < 85) begin
          c = pick_char();
          put_utf8(c);
          items += (c < 16'h80) ? 1 : (c < 16'h800) ? 2 : 3;
        end else begin
          txt(8'($urandom));
          items++;
        end
        if (k == 10 && phase == 1) drain();
      end
    end
    txt(8'h00);
    drain();
    $display("Covered %0d random text bytes, %0d decoded chars over 4 register phases",
             items, chars_seen);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
src/utg_pkg.sv
src/utg_in_if.sv
src/utg_out_if.sv
src/utf8_text_glyph_fetch.sv
tb/sv/utg_glyph_checker.sv
tb/sv/utf8_text_glyph_fetch_tb.sv
